// ===== design/mbfr_pkg.sv =====
// Package for the MSB-first bit field reader: sizes, opcodes and field packing.
package mbfr_pkg;

  // Store geometry
  localparam int STORE_BYTES = 1024;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CNT_W       = $clog2(STORE_BYTES + 1);
  localparam int POS_W       = CNT_W + 3;

  // Field geometry: up to 32 bits, spanning at most five stored bytes
  localparam int FIELD_W   = 32;
  localparam int MAX_BYTES = 5;
  localparam int WIN_W     = 8 * MAX_BYTES;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_READ   = 2'd1,
    OP_REWIND = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Pack a bit window into the result: full groups of eight keep their order
  // MSB-first in their byte, a trailing partial group is right-aligned.
  function automatic logic [FIELD_W-1:0] pack_field(input logic [WIN_W-1:0] win,
                                                    input logic [2:0] bit_pos,
                                                    input logic [5:0] cnt);
    logic [WIN_W-1:0]   strm;
    logic [FIELD_W-1:0] res;
    logic [7:0]         sb;
    logic [5:0]         lo;
    logic [3:0]         n;
    strm = win << bit_pos;
    res  = '0;
    for (int g = 0; g < 4; g++) begin
      sb = strm[WIN_W-1-8*g -: 8];
      lo = 6'(8 * g);
      n  = 4'(cnt - lo);
      if (cnt >= 6'(8 * g + 8)) begin
        res[8*g +: 8] = sb;
      end else if (cnt > lo) begin
        res[8*g +: 8] = sb >> (4'd8 - n);
      end
    end
    return res;
  endfunction

endpackage

// ===== design/msb_first_bit_field_reader_unit.sv =====
// Top level of the MSB-first bit field reader: byte store, position and read sequencer.
//
// Usage: drive in_opcode, in_byte_in and in_bit_count with start high; the
// item is taken at a clock edge where start is high and busy is low.
// Load, rewind and clear items finish in their accept cycle, so busy stays
// low and another item may follow in the next cycle.
// A read item saturates its bit count to 32 and fetches the ceil((bit
// offset + count) / 8) stored bytes it spans, zero to five, one per cycle
// through the store's single read port (registered read data). The result
// appears on out_field_value with out_strobe high for one cycle once the
// last byte is captured, or with no fetch at all for a field that spans
// no stored byte (zero bits at a byte boundary). Busy is high meanwhile and
// drops in the strobe cycle, so the next item can be taken at the end of
// the strobe cycle.
// Bytes past the loaded data read as zero; the position stops at the end.
// The receiver cannot hold results off: each result is valid for exactly
// one cycle. Reset clears the loaded count and the position; store
// contents are left as they are and need no clearing pass.
module msb_first_bit_field_reader_unit
  import mbfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_byte_in,
  input  logic [5:0]         in_bit_count,
  output logic               out_strobe,
  output logic [FIELD_W-1:0] out_field_value
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   loaded_r;
  logic [POS_W-1:0]   pos_r;
  logic [5:0]         cnt_r;
  logic [2:0]         nb_r;
  logic [2:0]         j_r;
  logic [2:0]         idx_r;
  logic               vld_r;
  logic [WIN_W-1:0]   win_r;
  logic               out_strobe_r;
  logic [FIELD_W-1:0] out_field_value_r;

  logic               accept;
  op_t                op;
  logic [5:0]         cnt_sat;
  logic [6:0]         need_bits;
  logic [2:0]         nb_nxt;
  logic [CNT_W-1:0]   byte_pos;
  logic [CNT_W:0]     rd_byte;
  logic [CNT_W:0]     cap_byte;
  logic               issue;
  logic               wr_en;
  logic [7:0]         rdata;
  logic [POS_W-1:0]   avail;
  logic [POS_W-1:0]   adv;
  logic [POS_W-1:0]   pos_nxt;

  assign accept   = start && !busy;
  assign op       = op_t'(in_opcode);
  assign busy     = (state_r != S_IDLE);
  assign byte_pos = pos_r[POS_W-1:3];

  // saturate count and work out how many stored bytes the field spans
  // (at most 7 + 32 + 7 = 46, so bit 6 of need_bits is always clear)
  assign cnt_sat   = (in_bit_count > 6'd32) ? 6'd32 : in_bit_count;
  assign need_bits = 7'(pos_r[2:0]) + 7'(cnt_sat) + 7'd7;
  assign nb_nxt    = need_bits[5:3];

  // read addressing and capture bookkeeping
  assign rd_byte  = (CNT_W + 1)'(byte_pos) + (CNT_W + 1)'(j_r);
  assign cap_byte = (CNT_W + 1)'(byte_pos) + (CNT_W + 1)'(idx_r);
  assign issue    = (state_r == S_READ) && (j_r < nb_r);

  // load writes at the fill count while room remains
  assign wr_en = accept && (op == OP_LOAD) && (loaded_r < CNT_W'(STORE_BYTES));

  mbfr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(loaded_r[ADDR_W-1:0]),
    .wdata(in_byte_in),
    .re   (issue),
    .raddr(rd_byte[ADDR_W-1:0]),
    .rdata(rdata)
  );

  // position advance: consume no more bits than remain in the packet
  assign avail   = {loaded_r, 3'b000} - pos_r;
  assign adv     = (POS_W'(cnt_r) < avail) ? POS_W'(cnt_r) : avail;
  assign pos_nxt = pos_r + adv;

  // sequencer, position and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      loaded_r     <= '0;
      pos_r        <= '0;
      vld_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      vld_r        <= issue;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_LOAD: begin
                if (wr_en) begin
                  loaded_r <= loaded_r + CNT_W'(1);
                end
              end
              OP_READ: begin
                cnt_r <= cnt_sat;
                nb_r  <= nb_nxt;
                j_r   <= '0;
                win_r <= '0;
                state_r <= (nb_nxt == 3'd0) ? S_OUT : S_READ;
              end
              OP_REWIND: begin
                pos_r <= '0;
              end
              OP_CLEAR: begin
                pos_r    <= '0;
                loaded_r <= '0;
              end
            endcase
          end
        end
        S_READ: begin
          if (issue) begin
            j_r   <= j_r + 3'd1;
            idx_r <= j_r;
          end
          // bytes past the loaded data count as zero
          if (vld_r) begin
            win_r[WIN_W-1-8*idx_r -: 8] <=
              (cap_byte < (CNT_W + 1)'(loaded_r)) ? rdata : 8'h00;
            if (j_r == nb_r) begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          out_strobe_r      <= 1'b1;
          out_field_value_r <= pack_field(win_r, pos_r[2:0], cnt_r);
          pos_r             <= pos_nxt;
          state_r           <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_field_value = out_field_value_r;

  // a result comes only from the output step of the sequencer
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == S_OUT))
    else $error("result strobe without output step");

  // the fill count never passes the store size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CNT_W'(STORE_BYTES))
    else $error("fill count beyond store size");

  // the read position never passes the end of the loaded data
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= {loaded_r, 3'b000})
    else $error("read position beyond loaded data");

  // the block is free again once a result is shown
  a_free_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> !busy)
    else $error("busy while result shown");

endmodule

// ===== design/mbfr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mbfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench for the MSB-first bit field reader: directed table, random packets, self-check.
`timescale 1ns / 1ps

module tb;
  import mbfr_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int DIR_ROWS    = 23;

  // One row of the directed table; fixed marks a result typed in by hand
  typedef struct {
    op_t                op;
    logic [7:0]         data;
    logic [5:0]         cnt;
    bit                 fixed;
    logic [FIELD_W-1:0] val;
  } dir_row_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               start        = 1'b0;
  logic [1:0]         in_opcode    = OP_LOAD;
  logic [7:0]         in_byte_in   = 8'h00;
  logic [5:0]         in_bit_count = 6'd0;
  logic               busy;
  logic               out_strobe;
  logic [FIELD_W-1:0] out_field_value;

  // Shadow of the reader state
  logic [7:0]  pkt_mem [STORE_BYTES];
  int unsigned pkt_len;
  int unsigned rd_byte;
  int unsigned rd_bit;

  logic [FIELD_W-1:0] expected_fields [$];
  int unsigned        items_sent;
  int unsigned        reads_sent;
  int unsigned        fields_checked;
  int unsigned        packets_sent;
  int unsigned        mismatches;
  int unsigned        stall_cycles;
  int unsigned        idle_pct;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_READ,   8'h00, 6'd0,  1'b1, 32'h0000_0000},  // zero bits after reset
    '{OP_READ,   8'hff, 6'd32, 1'b1, 32'h0000_0000},  // empty packet
    '{OP_LOAD,   8'ha5, 6'd0,  1'b0, 32'h0},
    '{OP_LOAD,   8'hff, 6'd63, 1'b0, 32'h0},
    '{OP_LOAD,   8'h00, 6'd0,  1'b0, 32'h0},
    '{OP_LOAD,   8'h81, 6'd0,  1'b0, 32'h0},
    '{OP_LOAD,   8'h3c, 6'd0,  1'b0, 32'h0},
    '{OP_READ,   8'h00, 6'd1,  1'b1, 32'h0000_0001},
    '{OP_READ,   8'h00, 6'd7,  1'b0, 32'h0},          // partial group, unaligned
    '{OP_READ,   8'h00, 6'd0,  1'b1, 32'h0000_0000},
    '{OP_READ,   8'h00, 6'd63, 1'b0, 32'h0},          // saturates, reads to the end
    '{OP_READ,   8'h00, 6'd8,  1'b1, 32'h0000_0000},
    '{OP_REWIND, 8'h5a, 6'd17, 1'b0, 32'h0},
    '{OP_READ,   8'h00, 6'd32, 1'b1, 32'h8100_ffa5},
    '{OP_READ,   8'h00, 6'd8,  1'b1, 32'h0000_003c},
    '{OP_READ,   8'h00, 6'd5,  1'b1, 32'h0000_0000},  // past the data
    '{OP_REWIND, 8'h00, 6'd0,  1'b0, 32'h0},
    '{OP_READ,   8'h00, 6'd40, 1'b0, 32'h0},
    '{OP_CLEAR,  8'hff, 6'd63, 1'b0, 32'h0},
    '{OP_READ,   8'h00, 6'd16, 1'b1, 32'h0000_0000},  // cleared packet reads zero
    '{OP_LOAD,   8'h00, 6'd0,  1'b0, 32'h0},
    '{OP_LOAD,   8'hff, 6'd0,  1'b0, 32'h0},
    '{OP_READ,   8'h00, 6'd12, 1'b0, 32'h0}
  };

  msb_first_bit_field_reader_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_byte_in      (in_byte_in),
    .in_bit_count    (in_bit_count),
    .out_strobe      (out_strobe),
    .out_field_value (out_field_value)
  );

  always #6 clk = ~clk;

  // Advance the shadow state by one accepted item, queue the field it returns
  function automatic void update_reader(input op_t op, input logic [7:0] data,
                                        input logic [5:0] cnt, input bit fixed,
                                        input logic [FIELD_W-1:0] fixed_val);
    int unsigned        nbits;
    int unsigned        grp;
    int unsigned        glen;
    logic               bitv;
    logic [FIELD_W-1:0] field;
    nbits = (cnt > 6'd32) ? 32 : cnt;
    field = '0;
    case (op)
      OP_LOAD: begin
        // full store drops the byte
        if (pkt_len < STORE_BYTES) begin
          pkt_mem[pkt_len] = data;
          pkt_len++;
        end
      end
      OP_READ: begin
        for (int unsigned k = 0; k < nbits; k++) begin
          grp  = k / 8;
          glen = (nbits - 8 * grp < 8) ? nbits - 8 * grp : 8;
          bitv = 1'b0;
          // position holds once the data runs out
          if (rd_byte < pkt_len) begin
            bitv = pkt_mem[rd_byte][7 - rd_bit];
            rd_bit++;
            if (rd_bit == 8) begin
              rd_bit = 0;
              rd_byte++;
            end
          end
          field[8 * grp + glen - 1 - k % 8] = bitv;
        end
        expected_fields.push_back(fixed ? fixed_val : field);
        reads_sent++;
      end
      OP_REWIND: begin
        rd_byte = 0;
        rd_bit  = 0;
      end
      default: begin
        pkt_len = 0;
        rd_byte = 0;
        rd_bit  = 0;
      end
    endcase
  endfunction

  // Drive one item after random idle cycles, wait for the accept edge
  task automatic issue_item(input op_t op, input logic [7:0] data, input logic [5:0] cnt,
                            input bit fixed = 1'b0, input logic [FIELD_W-1:0] fixed_val = '0);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_opcode    <= op;
    in_byte_in   <= data;
    in_bit_count <= cnt;
    do @(posedge clk); while (busy);
    update_reader(op, data, cnt, fixed, fixed_val);
    items_sent++;
  endtask

  // Hold the sender off until every queued field has come back
  task automatic drain_fields();
    start <= 1'b0;
    do @(posedge clk); while (expected_fields.size() != 0);
  endtask

  task automatic issue_read(input bit wide);
    int unsigned pick;
    logic [5:0]  cnt;
    pick = $urandom_range(99);
    if (wide)
      cnt = 6'($urandom_range(24, 63));
    else if (pick < 10)
      cnt = 6'd0;
    else if (pick < 25)
      cnt = 6'($urandom_range(33, 63));
    else
      cnt = 6'($urandom_range(1, 32));
    issue_item(OP_READ, 8'($urandom_range(255)), cnt);
  endtask

  // One packet: clear, loads, then a mix of reads, rewinds and stray items.
  // A full packet fills the store past the top and reads it to the end.
  task automatic run_packet(input bit full);
    int unsigned nload;
    int unsigned nops;
    int unsigned pick;
    issue_item(OP_CLEAR, 8'($urandom_range(255)), 6'($urandom_range(63)));
    if (full)
      nload = STORE_BYTES + 4;
    else if ($urandom_range(9) == 0)
      nload = $urandom_range(13, 48);
    else
      nload = $urandom_range(0, 12);
    for (int unsigned i = 0; i < nload; i++)
      issue_item(OP_LOAD, 8'($urandom_range(255)), 6'($urandom_range(63)));
    if (full) begin
      while (rd_byte < pkt_len)
        issue_read(1'b1);
      repeat (3) issue_read(1'b0);
    end else begin
      nops = $urandom_range(4, 16);
      for (int unsigned i = 0; i < nops; i++) begin
        if ($urandom_range(49) == 0)
          drain_fields();
        pick = $urandom_range(99);
        if (pick < 70)
          issue_read(1'b0);
        else if (pick < 80)
          issue_item(OP_REWIND, 8'($urandom_range(255)), 6'($urandom_range(63)));
        else if (pick < 90)
          issue_item(OP_LOAD, 8'($urandom_range(255)), 6'($urandom_range(63)));
        else if (pick < 96)
          issue_item(op_t'($urandom_range(3)), 8'($urandom_range(255)),
                     6'($urandom_range(63)));
        else
          issue_item(OP_CLEAR, 8'($urandom_range(255)), 6'($urandom_range(63)));
      end
    end
    packets_sent++;
  endtask

  // Result checker: every strobe pops the oldest expected field
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_fields.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %h", $time, out_field_value);
        mismatches++;
      end else begin
        if (out_field_value !== expected_fields[0]) begin
          $display("%0t: field_value mismatch: expected %h, got %h",
                   $time, expected_fields[0], out_field_value);
          mismatches++;
        end
        void'(expected_fields.pop_front());
        fields_checked++;
      end
    end
  end

  // Watchdog on cycles with no item accepted and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout with %0d fields outstanding", $time, expected_fields.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    pkt_len        = 0;
    rd_byte        = 0;
    rd_bit         = 0;
    items_sent     = 0;
    reads_sent     = 0;
    fields_checked = 0;
    packets_sent   = 0;
    mismatches     = 0;
    stall_cycles   = 0;
    idle_pct       = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (dir_rows[i])
      issue_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].cnt,
                 dir_rows[i].fixed, dir_rows[i].val);
    drain_fields();

    // Random packets, sender idling at two rates, then back to back
    idle_pct = 34;
    while (items_sent < 320) run_packet(1'b0);
    drain_fields();
    idle_pct = 49;
    while (items_sent < 560) run_packet(1'b0);
    drain_fields();
    idle_pct = 0;
    run_packet(1'b1);
    while (items_sent < 1850) run_packet(1'b0);

    // Wait out the last results
    start <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d items in %0d packets, one filling the store past the top;",
             items_sent, packets_sent);
    $display("%0d field reads issued, %0d results checked, %0d mismatches.",
             reads_sent, fields_checked, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
